@@ rtl/core/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, types and helpers for the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int CELL_W  = 16;

  // Field widths fixed by the stream format
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int ATTR_W  = 8;

  localparam logic [CHAR_W-1:0] NL_BYTE    = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_BYTE = 8'd32;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd15;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [ATTR_W-1:0] read_color;
    logic [CHAR_W-1:0] read_char;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
  } res_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(int'(row) * COLUMNS + int'(col));
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// 80x25 character/attribute console with a cursor, held in one screen RAM.
// ----------------------------------------------------------------------------
// Put char / newline without scroll / bad read: result registered in the cycle
//   after the request; cell read: via S_READ, then the result (one RAM read).
// Throughput: one request per cycle for plain puts while the result slot is free
//   or draining; a scroll runs a copy pass, a blank sweep of the bottom row and
//   a finish step; clear screen runs a full blank sweep and a finish step. The
//   single RAM write port sets this. Reset: synchronous, active low; a clearing
//   pass fills the RAM with blanks in color 15 while in_tready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // character[7:0], cell_row[12:8], cell_col[19:13]
  input  wire logic [1:0]  in_tuser,   // op[1:0]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // cursor_row[4:0], cursor_col[11:5],
                                       // read_char[19:12], read_color[27:20]
  // color register
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int ADDR_W = tcw_pkg::ADDR_W;
  localparam int CNT_W  = tcw_pkg::CNT_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;  // waiting on RAM read data
  localparam logic [2:0] S_SCROLL = 3'd2;  // copy rows up one
  localparam logic [2:0] S_FILL   = 3'd3;  // blank sweep (clear, scroll tail, boot)
  localparam logic [2:0] S_FINISH = 3'd4;  // deferred put after scroll, result

  // request fields
  logic [tcw_pkg::OP_W-1:0]   in_op;
  logic [tcw_pkg::CHAR_W-1:0] in_char;
  logic [tcw_pkg::ROW_W-1:0]  in_row;
  logic [tcw_pkg::COL_W-1:0]  in_col;

  assign in_op   = in_tuser;
  assign in_char = in_tdata[7:0];
  assign in_row  = in_tdata[12:8];
  assign in_col  = in_tdata[19:13];

  // state
  logic [2:0]                   st_r, st_nxt;
  logic [tcw_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic [tcw_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         pput_r, pput_nxt;   // char waits for scroll to end
  logic [tcw_pkg::CHAR_W-1:0]   pch_r, pch_nxt;
  logic [tcw_pkg::ATTR_W-1:0]   fattr_r, fattr_nxt; // blank color of the sweep
  logic                         boot_r, boot_nxt;   // sweep is the reset pass
  logic [tcw_pkg::ATTR_W-1:0]   color_r;
  logic                         ovld_r, ovld_nxt;
  tcw_pkg::res_t                res_r, res_nxt;

  // RAM port
  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]            ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]   ram_rdata;

  logic in_fire;
  logic last_row;
  logic wrap;
  logic rd_ok;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Only this block loads the result register, so an output slot that is free
  // (or draining) at accept stays free until the request completes.
  assign in_tready = (st_r == S_IDLE) && (!ovld_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  assign last_row = (row_r == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
  assign wrap     = (col_r >= tcw_pkg::COL_W'(tcw_pkg::COLUMNS));
  assign rd_ok    = (int'(in_row) < tcw_pkg::ROWS) && (int'(in_col) < tcw_pkg::COLUMNS);

  always_comb begin
    st_nxt    = st_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    cnt_nxt   = cnt_r;
    pput_nxt  = pput_r;
    pch_nxt   = pch_r;
    fattr_nxt = fattr_r;
    boot_nxt  = boot_r;
    ovld_nxt  = ovld_r && !out_tready;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;

    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          // default result: cursor after the request, no read data
          res_nxt.read_char  = '0;
          res_nxt.read_color = '0;
          case (in_op)
            tcw_pkg::OP_PUT: begin
              if (in_char == tcw_pkg::NL_BYTE || wrap) begin
                // newline, explicit or from a pending wrap
                if (!last_row) begin
                  row_nxt = tcw_pkg::ROW_W'(row_r + 1'b1);
                  if (in_char == tcw_pkg::NL_BYTE) begin
                    col_nxt = '0;
                  end else begin
                    ram_we    = 1'b1;
                    ram_waddr = tcw_pkg::cell_addr(row_nxt, '0);
                    ram_wdata = {color_r, in_char};
                    col_nxt   = tcw_pkg::COL_W'(1);
                  end
                  ovld_nxt           = 1'b1;
                  res_nxt.cursor_row = row_nxt;
                  res_nxt.cursor_col = col_nxt;
                end else begin
                  // scroll; a printable byte lands on the new bottom row after
                  pput_nxt  = (in_char != tcw_pkg::NL_BYTE);
                  pch_nxt   = in_char;
                  col_nxt   = (in_char != tcw_pkg::NL_BYTE) ? tcw_pkg::COL_W'(1) : '0;
                  fattr_nxt = color_r;
                  cnt_nxt   = CNT_W'(tcw_pkg::COLUMNS);
                  st_nxt    = S_SCROLL;
                end
              end else begin
                ram_we             = 1'b1;
                ram_waddr          = tcw_pkg::cell_addr(row_r, col_r);
                ram_wdata          = {color_r, in_char};
                col_nxt            = tcw_pkg::COL_W'(col_r + 1'b1);
                ovld_nxt           = 1'b1;
                res_nxt.cursor_row = row_r;
                res_nxt.cursor_col = col_nxt;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              fattr_nxt = color_r;
              cnt_nxt   = '0;
              st_nxt    = S_FILL;
            end
            tcw_pkg::OP_READ: begin
              if (rd_ok) begin
                ram_raddr = tcw_pkg::cell_addr(in_row, in_col);
                st_nxt    = S_READ;
              end else begin
                ovld_nxt           = 1'b1;
                res_nxt.cursor_row = row_r;
                res_nxt.cursor_col = col_r;
              end
            end
            default: begin
              // unused op: cursor only
              ovld_nxt           = 1'b1;
              res_nxt.cursor_row = row_r;
              res_nxt.cursor_col = col_r;
            end
          endcase
        end
      end

      S_READ: begin
        ovld_nxt           = 1'b1;
        res_nxt.cursor_row = row_r;
        res_nxt.cursor_col = col_r;
        res_nxt.read_char  = ram_rdata[7:0];
        res_nxt.read_color = ram_rdata[15:8];
        st_nxt             = S_IDLE;
      end

      S_SCROLL: begin
        // read cell cnt, write the previous read one row up
        if (cnt_r < CNT_W'(tcw_pkg::CELLS)) begin
          ram_raddr = ADDR_W'(cnt_r);
        end
        if (cnt_r > CNT_W'(tcw_pkg::COLUMNS)) begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(cnt_r - CNT_W'(tcw_pkg::COLUMNS + 1));
          ram_wdata = ram_rdata;
        end
        if (cnt_r == CNT_W'(tcw_pkg::CELLS)) begin
          cnt_nxt = CNT_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
          row_nxt = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
          st_nxt  = S_FILL;
        end else begin
          cnt_nxt = CNT_W'(cnt_r + 1'b1);
        end
      end

      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(cnt_r);
        ram_wdata = {fattr_r, tcw_pkg::BLANK_BYTE};
        if (cnt_r == CNT_W'(tcw_pkg::CELLS - 1)) begin
          st_nxt   = boot_r ? S_IDLE : S_FINISH;
          boot_nxt = 1'b0;
        end else begin
          cnt_nxt = CNT_W'(cnt_r + 1'b1);
        end
      end

      S_FINISH: begin
        if (pput_r) begin
          ram_we    = 1'b1;
          ram_waddr = tcw_pkg::cell_addr(row_r, '0);
          ram_wdata = {color_r, pch_r};
        end
        pput_nxt           = 1'b0;
        ovld_nxt           = 1'b1;
        res_nxt.cursor_row = row_r;
        res_nxt.cursor_col = col_r;
        res_nxt.read_char  = '0;
        res_nxt.read_color = '0;
        st_nxt             = S_IDLE;
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_FILL;               // boot clearing pass
      row_r   <= '0;
      col_r   <= '0;
      cnt_r   <= '0;
      pput_r  <= 1'b0;
      fattr_r <= tcw_pkg::RESET_ATTR;
      boot_r  <= 1'b1;
      color_r <= tcw_pkg::RESET_ATTR;
      ovld_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      cnt_r   <= cnt_nxt;
      pput_r  <= pput_nxt;
      fattr_r <= fattr_nxt;
      boot_r  <= boot_nxt;
      ovld_r  <= ovld_nxt;
      if (cfg_we) begin
        color_r <= cfg_wdata;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    pch_r <= pch_nxt;
    res_r <= res_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {4'd0, res_r};

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_console_writer. A table of directed requests
// is sent first: reset contents, reads out of range, the unused op, newline,
// wrap and scroll on the last row. Randomized phases follow, each under a
// newly set text color. The screen model, or a typed row's own value, gives
// each expected result; each result is compared field by field with the oldest.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 11;
  // Slowest quiet stretch is the reset clearing pass, a scroll or a clear, or
  // the long output hold below; take a wide margin.
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int HOLD_CYCLES    = 600;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 250;
  localparam int TAIL_CYCLES    = 8;
  localparam int DIR_ROWS       = 26;

  // op 3 is not decoded by the block; it only reports the cursor
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  // One row of the directed table. A config row carries the color in chr.
  // want is only used when typed is set; it is {color, char, col, row}.
  typedef struct packed {
    logic              is_cfg;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] chr;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [7:0]        reps;
    logic              typed;
    res_t              want;
  } stim_row_t;

  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    // power-up contents and reads that fall outside the screen
    '{1'b0, OP_READ,  8'h00,   5'd0,  7'd0,   8'd1,  1'b1,
      '{RESET_ATTR, BLANK_BYTE, 7'd0, 5'd0}},
    '{1'b0, OP_READ,  8'h00,   5'd24, 7'd79,  8'd1,  1'b1,
      '{RESET_ATTR, BLANK_BYTE, 7'd0, 5'd0}},
    '{1'b0, OP_READ,  8'h00,   5'd25, 7'd0,   8'd1,  1'b1, '0},
    '{1'b0, OP_READ,  8'h00,   5'd0,  7'd80,  8'd1,  1'b1, '0},
    '{1'b0, OP_READ,  8'hFF,   5'd31, 7'd127, 8'd1,  1'b1, '0},
    '{1'b0, OP_NONE,  8'hFF,   5'd31, 7'd127, 8'd1,  1'b1, '0},
    // plain bytes, extremes of the character field
    '{1'b0, OP_PUT,   8'h41,   5'd0,  7'd0,   8'd1,  1'b1, '{8'd0, 8'd0, 7'd1, 5'd0}},
    '{1'b0, OP_PUT,   8'h00,   5'd0,  7'd0,   8'd1,  1'b1, '{8'd0, 8'd0, 7'd2, 5'd0}},
    '{1'b0, OP_PUT,   8'hFF,   5'd0,  7'd0,   8'd1,  1'b1, '{8'd0, 8'd0, 7'd3, 5'd0}},
    '{1'b0, OP_READ,  8'h00,   5'd0,  7'd2,   8'd1,  1'b1,
      '{RESET_ATTR, 8'hFF, 7'd3, 5'd0}},
    '{1'b0, OP_PUT,   NL_BYTE, 5'd0,  7'd0,   8'd1,  1'b1, '{8'd0, 8'd0, 7'd0, 5'd1}},
    // color 0, then clear screen must blank in that color
    '{1'b1, OP_PUT,   8'h00,   5'd0,  7'd0,   8'd1,  1'b0, '0},
    '{1'b0, OP_PUT,   8'h7A,   5'd0,  7'd0,   8'd1,  1'b0, '0},
    '{1'b0, OP_READ,  8'h00,   5'd1,  7'd0,   8'd1,  1'b0, '0},
    '{1'b0, OP_CLEAR, 8'h00,   5'd0,  7'd0,   8'd1,  1'b1, '0},
    '{1'b0, OP_READ,  8'h00,   5'd1,  7'd0,   8'd1,  1'b1,
      '{8'h00, BLANK_BYTE, 7'd0, 5'd0}},
    // color FF: walk to the bottom, fill the row, wrap and scroll there
    '{1'b1, OP_PUT,   8'hFF,   5'd0,  7'd0,   8'd1,  1'b0, '0},
    '{1'b0, OP_PUT,   NL_BYTE, 5'd0,  7'd0,   8'd24, 1'b0, '0},
    '{1'b0, OP_PUT,   8'h71,   5'd0,  7'd0,   8'd80, 1'b0, '0},
    '{1'b0, OP_READ,  8'h00,   5'd24, 7'd79,  8'd1,  1'b0, '0},
    '{1'b0, OP_PUT,   8'h77,   5'd0,  7'd0,   8'd1,  1'b0, '0},
    '{1'b0, OP_READ,  8'h00,   5'd23, 7'd0,   8'd1,  1'b0, '0},
    '{1'b0, OP_PUT,   NL_BYTE, 5'd0,  7'd0,   8'd1,  1'b0, '0},
    '{1'b0, OP_READ,  8'h00,   5'd22, 7'd79,  8'd1,  1'b0, '0},
    '{1'b0, OP_READ,  8'h00,   5'd24, 7'd0,   8'd1,  1'b0, '0},
    '{1'b1, OP_PUT,   8'h5A,   5'd0,  7'd0,   8'd1,  1'b0, '0}
  };

  // DUT connections; every input starts at a known value
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // character[7:0], cell_row[12:8], cell_col[19:13]
  logic [1:0]  in_tuser   = '0;   // op[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // cursor_row[4:0], cursor_col[11:5],
                                  // read_char[19:12], read_color[27:20]
  logic        cfg_we     = 1'b0;
  logic [7:0]  cfg_wdata  = '0;

  // Screen model state
  logic [CELL_W-1:0] screen [CELLS];
  logic [ROW_W-1:0]  cur_r;
  logic [COL_W-1:0]  cur_c;
  logic [ATTR_W-1:0] color;

  res_t console_res_q [$];        // predicted results, oldest first

  // Run control shared between the sender, the sink and the watchdog
  bit tx_quiet;
  bit rx_quiet;
  int rx_hold;
  int mismatches;
  int idle_cycles;
  int n_req, n_read, n_res, n_scroll, n_wrap, n_clear;

  always #(CLK_PERIOD / 2) clk = ~clk;

  text_console_writer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Screen model
  // --------------------------------------------------------------------------

  // Cursor to column 0 of the next row; on the bottom row everything moves
  // up one row and the bottom row is blanked in the current color.
  function automatic void line_feed();
    cur_c = '0;
    if (int'(cur_r) < ROWS - 1) begin
      cur_r = cur_r + 1'b1;
    end else begin
      for (int i = COLUMNS; i < CELLS; i++) screen[i - COLUMNS] = screen[i];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {color, BLANK_BYTE};
      n_scroll++;
    end
  endfunction

  // Applies one request to the model and returns the result it must produce.
  function automatic res_t console_step(input logic [OP_W-1:0]   op,
                                        input logic [CHAR_W-1:0] ch,
                                        input logic [ROW_W-1:0]  row,
                                        input logic [COL_W-1:0]  col);
    res_t r;
    r = '0;
    case (op)
      OP_PUT: begin
        if (ch == NL_BYTE) begin
          line_feed();
        end else begin
          // column 80 means a wrap is pending: it happens on the next byte
          if (int'(cur_c) >= COLUMNS) begin
            line_feed();
            n_wrap++;
          end
          screen[int'(cur_r) * COLUMNS + int'(cur_c)] = {color, ch};
          cur_c = cur_c + 1'b1;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = {color, BLANK_BYTE};
        cur_r = '0;
        cur_c = '0;
        n_clear++;
      end
      OP_READ: begin
        n_read++;
        if (int'(row) < ROWS && int'(col) < COLUMNS)
          {r.read_color, r.read_char} = screen[int'(row) * COLUMNS + int'(col)];
      end
      default: ;  // unused op leaves everything alone
    endcase
    r.cursor_row = cur_r;
    r.cursor_col = cur_c;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offers one request after a random gap and records its prediction once the
  // block takes it. Leaves in_tvalid high so a back-to-back request needs no
  // second assignment in the same step.
  task automatic send_req(input logic [OP_W-1:0]   op,
                          input logic [CHAR_W-1:0] ch,
                          input logic [ROW_W-1:0]  row,
                          input logic [COL_W-1:0]  col,
                          input logic              typed,
                          input res_t              typed_res);
    int   gap;
    res_t pred;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, col, row, ch};
    do @(posedge clk); while (!in_tready);
    pred = console_step(op, ch, row, col);
    console_res_q.push_back(typed ? typed_res : pred);
    n_req++;
  endtask

  // Color changes only with the block idle: every result back and the input
  // ready again (a scroll or clear may still be blanking cells otherwise).
  task automatic set_color(input logic [ATTR_W-1:0] value);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (console_res_q.size() != 0 || !in_tready);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    color = value;
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  initial begin : result_sink
    int   stall;
    res_t got;
    res_t want;
    do @(posedge clk); while (!rst_n);
    forever begin
      // a pending hold request wins over the ordinary per-result stall
      if (rx_hold != 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_quiet ? 0 : $urandom_range(0, 16);
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = out_tdata[$bits(res_t)-1:0];
      n_res++;
      if (console_res_q.size() == 0) begin
        $display("%0t ns: result with no request outstanding, actual %h", $time, got);
        mismatches++;
      end else begin
        want = console_res_q.pop_front();
        check_field("cursor_row", want.cursor_row, got.cursor_row);
        check_field("cursor_col", want.cursor_col, got.cursor_col);
        check_field("read_char",  want.read_char,  got.read_char);
        check_field("read_color", want.read_color, got.read_color);
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t         ent;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    int                pick;

    for (int i = 0; i < CELLS; i++) screen[i] = {RESET_ATTR, BLANK_BYTE};
    cur_r = '0;
    cur_c = '0;
    color = RESET_ATTR;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; the block's clearing pass holds off the first request
    for (int i = 0; i < DIR_ROWS; i++) begin
      ent = DIR_TAB[i];
      if (ent.is_cfg) begin
        set_color(ent.chr);
      end else begin
        for (int k = 0; k < int'(ent.reps); k++)
          send_req(ent.op, ent.chr, ent.row, ent.col, ent.typed, ent.want);
      end
    end

    // random phases, each under its own color
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_color(8'h00);
        1:       set_color(8'hFF);
        default: set_color(8'($urandom));
      endcase
      // back-pressure: sink holds off while the sender keeps pushing
      if (ph == 1) rx_hold = HOLD_CYCLES;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 0) begin
          tx_quiet = ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        if (ph == 1 && k < 100) tx_quiet = 1'b1;

        // unused fields still carry random bits
        ch   = 8'($urandom);
        row  = 5'($urandom);
        col  = 7'($urandom);
        pick = $urandom_range(0, 999);
        if (pick < 15) begin
          op = OP_CLEAR;
        end else if (pick < 35) begin
          op = OP_NONE;
        end else if (pick < 280) begin
          op = OP_READ;
          // mostly on screen, often on the cursor row where writes just landed
          case ($urandom_range(0, 9))
            0:       ;
            1, 2, 3: row = cur_r;
            default: row = 5'($urandom_range(0, ROWS - 1));
          endcase
          if ($urandom_range(0, 9) != 0) col = 7'($urandom_range(0, COLUMNS - 1));
        end else begin
          op = OP_PUT;
          if ($urandom_range(0, 99) < 7) ch = NL_BYTE;
        end
        send_req(op, ch, row, col, 1'b0, '0);
      end
    end

    // drain, then give a late or extra result time to show up
    in_tvalid <= 1'b0;
    while (console_res_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run: %0d requests (%0d cell reads), %0d results compared.",
             n_req, n_read, n_res);
    $display("Model saw %0d scrolls, %0d line wraps, %0d screen clears.",
             n_scroll, n_wrap, n_clear);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
